[rtl/core/smtm_pkg.sv]
// shared types and constants of the sorted multi-timer manager
package smtm_pkg;

    localparam int NUM_SLOTS_DEF = 32;
    localparam int MAX_EXPIRY    = 32;
    localparam int TIME_W        = 32;
    localparam int TAG_W         = 32;
    localparam int QUEUE_W       = 8;
    localparam int TSS_W         = 6;

    typedef enum logic [2:0] {
        FN_TICK,
        FN_ALLOC,
        FN_FREE,
        FN_TAG,
        FN_ARM,
        FN_CANCEL,
        FN_CANCEL_ALL,
        FN_NONE
    } func_t;

    typedef enum logic [1:0] {
        KIND_ACK,
        KIND_ALLOC,
        KIND_FULL,
        KIND_EXPIRY
    } kind_t;

    typedef enum logic [1:0] {
        ST_FREE,
        ST_ALLOC,
        ST_ARMED
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_POP
    } chain_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_INSERT,
        S_TICK,
        S_SWEEP,
        S_ACK
    } state_t;

    typedef struct packed {
        chain_op_t          op;
        logic [TIME_W-1:0]  dl;
    } chain_ctl_t;

    typedef struct packed {
        logic [2:0]               func;
        logic [4:0]               slot_index;
        logic [TIME_W-1:0]        delay_ticks;
        logic signed [TAG_W-1:0]  tag_value;
        logic [QUEUE_W-1:0]       queue_id;
        logic                     auto_cancel;
    } in_word_t;

    typedef struct packed {
        logic [1:0]               kind;
        logic [4:0]               out_slot;
        logic signed [TAG_W-1:0]  out_tag;
        logic [QUEUE_W-1:0]       out_queue;
        logic                     switch_request;
        logic                     was_cancelled;
        logic                     last;
    } out_word_t;

endpackage

[rtl/core/smtm_cell.sv]
// one cell of the deadline-ordered chain
module smtm_cell
    import smtm_pkg::*;
#(
    parameter int SLW = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  chain_ctl_t        ctl,
    input  logic [SLW-1:0]    op_slot,
    input  logic              left_vld,
    input  logic [SLW-1:0]    left_slot,
    input  logic [TIME_W-1:0] left_dl,
    input  logic              right_vld,
    input  logic [SLW-1:0]    right_slot,
    input  logic [TIME_W-1:0] right_dl,
    input  logic              ins_in,
    output logic              ins_out,
    input  logic              rem_in,
    output logic              rem_out,
    output logic              vld,
    output logic [SLW-1:0]    slot,
    output logic [TIME_W-1:0] dl
);

    logic              vld_reg, vld_next;
    logic [SLW-1:0]    slot_reg, slot_next;
    logic [TIME_W-1:0] dl_reg, dl_next;

    assign ins_out = !vld_reg || (ctl.dl <= dl_reg);
    assign rem_out = rem_in || (vld_reg && (slot_reg == op_slot));

    always_comb
    begin
        vld_next  = vld_reg;
        slot_next = slot_reg;
        dl_next   = dl_reg;
        case (ctl.op)
            OP_INSERT:
            begin
                if (ins_in)
                begin
                    vld_next  = left_vld;
                    slot_next = left_slot;
                    dl_next   = left_dl;
                end
                else if (ins_out)
                begin
                    vld_next  = 1'b1;
                    slot_next = op_slot;
                    dl_next   = ctl.dl;
                end
            end
            OP_REMOVE:
            begin
                if (rem_out)
                begin
                    vld_next  = right_vld;
                    slot_next = right_slot;
                    dl_next   = right_dl;
                end
            end
            OP_POP:
            begin
                vld_next  = right_vld;
                slot_next = right_slot;
                dl_next   = right_dl;
            end
            default:
            begin
                vld_next = vld_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        dl_reg   <= dl_next;
    end

    assign vld  = vld_reg;
    assign slot = slot_reg;
    assign dl   = dl_reg;

endmodule

[rtl/core/smtm_chain.sv]
// row of cells holding armed slots in ascending deadline order
module smtm_chain
    import smtm_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    parameter int SLW       = $clog2(NUM_SLOTS)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  chain_ctl_t        ctl,
    input  logic [SLW-1:0]    op_slot,
    output logic              head_vld,
    output logic [SLW-1:0]    head_slot,
    output logic [TIME_W-1:0] head_dl,
    output logic              next_vld,
    output logic [TIME_W-1:0] next_dl
);

    // cell i sits at position i+1, the ends are empty
    logic              c_vld  [NUM_SLOTS+2];
    logic [SLW-1:0]    c_slot [NUM_SLOTS+2];
    logic [TIME_W-1:0] c_dl   [NUM_SLOTS+2];
    logic              ins    [NUM_SLOTS+1];
    logic              rem    [NUM_SLOTS+1];

    assign c_vld[0]            = 1'b0;
    assign c_slot[0]           = '0;
    assign c_dl[0]             = '0;
    assign c_vld[NUM_SLOTS+1]  = 1'b0;
    assign c_slot[NUM_SLOTS+1] = '0;
    assign c_dl[NUM_SLOTS+1]   = '0;
    assign ins[0]              = 1'b0;
    assign rem[0]              = 1'b0;

    genvar i;
    generate
        for (i = 0; i < NUM_SLOTS; i++)
        begin : g_cell
            smtm_cell #(.SLW(SLW)) u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .op_slot    (op_slot),
                .left_vld   (c_vld[i]),
                .left_slot  (c_slot[i]),
                .left_dl    (c_dl[i]),
                .right_vld  (c_vld[i+2]),
                .right_slot (c_slot[i+2]),
                .right_dl   (c_dl[i+2]),
                .ins_in     (ins[i]),
                .ins_out    (ins[i+1]),
                .rem_in     (rem[i]),
                .rem_out    (rem[i+1]),
                .vld        (c_vld[i+1]),
                .slot       (c_slot[i+1]),
                .dl         (c_dl[i+1])
            );
        end
    endgenerate

    assign head_vld  = c_vld[1] && ins[NUM_SLOTS] && rem[NUM_SLOTS] ? c_vld[1] : c_vld[1];
    assign head_slot = c_slot[1];
    assign head_dl   = c_dl[1];
    assign next_vld  = c_vld[2];
    assign next_dl   = c_dl[2];

endmodule

[rtl/core/sorted_multi_timer_manager_unit.sv]
// top level of the sorted multi-timer manager
//
// in channel: in_valid/in_ready carry one command word (in_word_t), out channel:
// out_valid/out_ready carry result words (out_word_t), last marks the final
// word of a command. cfg_we/cfg_data write the task-switch slot at any edge.
// a command is taken only while the sequencer is idle; its results leave
// through a one-word output register, so a stalled receiver holds the
// sequencer in place and nothing is lost.
// steps: set tag, free, cancel, unused func: exec, then the ack word;
// allocate: exec, which gives the word; arm: exec, insert if the slot is
// allocated, ack; cancel all: exec, a sweep over the slots (one slot per
// cycle), ack; tick: exec, then one expiry word per due slot, or an ack word.
// the chain of cells does one insert, remove or head pop per cycle.
// reset: tick count zero, all slots free, chain empty, no task-switch slot.
module sorted_multi_timer_manager_unit
    import smtm_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_word_t         in_word,
    output logic             out_valid,
    input  logic             out_ready,
    output out_word_t        out_word,
    input  logic             cfg_we,
    input  logic [TSS_W-1:0] cfg_data
);

    localparam int SLW = $clog2(NUM_SLOTS);
    localparam int CW  = $clog2(MAX_EXPIRY + 1);

    state_t            state_reg, state_next;
    in_word_t          cmd_reg, cmd_next;
    logic [TIME_W-1:0] tick_reg, tick_next;
    logic [TSS_W-1:0]  tss_reg;
    logic [CW-1:0]     n_reg, n_next;
    logic [SLW-1:0]    sweep_reg, sweep_next;
    logic              canc_reg, canc_next;
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_word_reg, out_word_next;

    status_t              status_reg [NUM_SLOTS];
    logic                 ac_reg     [NUM_SLOTS];
    logic [TAG_W-1:0]     tag_reg    [NUM_SLOTS];
    logic [QUEUE_W-1:0]   queue_reg  [NUM_SLOTS];

    chain_ctl_t        ctl;
    logic [SLW-1:0]    op_slot;
    logic              head_vld, next_vld;
    logic [SLW-1:0]    head_slot;
    logic [TIME_W-1:0] head_dl, next_dl;

    func_t             fn;
    logic              accept, out_free, cmd_ok;
    logic [SLW-1:0]    cmd_idx, rd_idx;
    logic              free_found;
    logic [SLW-1:0]    free_idx;
    logic              due, more_due, sweep_end, sweep_hit;
    logic              st_we;
    logic [SLW-1:0]    st_idx;
    status_t           st_val;
    logic              ac_we, ac_val, tag_we;
    logic [SLW-1:0]    ac_idx;
    logic              emit;
    out_word_t         emit_word;

    assign fn        = func_t'(cmd_reg.func);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cmd_ok    = 32'(cmd_reg.slot_index) < NUM_SLOTS;
    assign cmd_idx   = SLW'(cmd_reg.slot_index);
    assign rd_idx    = (state_reg == S_TICK) ? head_slot : sweep_reg;
    assign due       = head_vld && (head_dl <= tick_reg);
    assign more_due  = next_vld && (next_dl <= tick_reg) && (n_reg != CW'(MAX_EXPIRY - 1));
    assign sweep_end = sweep_reg == SLW'(NUM_SLOTS - 1);
    assign sweep_hit = (status_reg[sweep_reg] != ST_FREE) && ac_reg[sweep_reg]
                       && (queue_reg[rd_idx] == cmd_reg.queue_id);
    assign in_ready  = state_reg == S_IDLE;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (status_reg[i] == ST_FREE)
            begin
                free_found = 1'b1;
                free_idx   = SLW'(i);
            end
        end
    end

    smtm_chain #(.NUM_SLOTS(NUM_SLOTS), .SLW(SLW)) u_chain
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .op_slot   (op_slot),
        .head_vld  (head_vld),
        .head_slot (head_slot),
        .head_dl   (head_dl),
        .next_vld  (next_vld),
        .next_dl   (next_dl)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                case (fn)
                    FN_TICK:       state_next = S_TICK;
                    FN_ALLOC:      state_next = out_free ? S_IDLE : S_EXEC;
                    FN_ARM:        state_next = (cmd_ok && status_reg[cmd_idx] != ST_FREE)
                                                ? S_INSERT : S_ACK;
                    FN_CANCEL_ALL: state_next = S_SWEEP;
                    default:       state_next = S_ACK;
                endcase
            end
            S_INSERT:
            begin
                state_next = S_ACK;
            end
            S_SWEEP:
            begin
                if (sweep_end)
                    state_next = S_ACK;
            end
            S_ACK:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            S_TICK:
            begin
                if (out_free && !(due && more_due))
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath control and result words
    always_comb
    begin
        cmd_next   = cmd_reg;
        tick_next  = tick_reg;
        n_next     = n_reg;
        sweep_next = sweep_reg;
        canc_next  = canc_reg;
        ctl.op     = OP_HOLD;
        ctl.dl     = cmd_reg.delay_ticks + tick_reg;
        op_slot    = cmd_idx;
        st_we      = 1'b0;
        st_idx     = cmd_idx;
        st_val     = ST_ALLOC;
        ac_we      = 1'b0;
        ac_idx     = cmd_idx;
        ac_val     = cmd_reg.auto_cancel;
        tag_we     = 1'b0;
        emit       = 1'b0;
        emit_word  = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = in_word;
                    n_next    = '0;
                    canc_next = 1'b0;
                    if (func_t'(in_word.func) == FN_TICK)
                        tick_next = tick_reg + 1'b1;
                end
            end
            S_EXEC:
            begin
                case (fn)
                    FN_ALLOC:
                    begin
                        if (out_free)
                        begin
                            emit           = 1'b1;
                            emit_word.last = 1'b1;
                            if (free_found)
                            begin
                                emit_word.kind     = KIND_ALLOC;
                                emit_word.out_slot = 5'(free_idx);
                                st_we              = 1'b1;
                                st_idx             = free_idx;
                                ac_we              = 1'b1;
                                ac_idx             = free_idx;
                                ac_val             = 1'b0;
                            end
                            else
                            begin
                                emit_word.kind = KIND_FULL;
                            end
                        end
                    end
                    FN_FREE:
                    begin
                        if (cmd_ok)
                        begin
                            if (status_reg[cmd_idx] == ST_ARMED)
                                ctl.op = OP_REMOVE;
                            st_we  = 1'b1;
                            st_val = ST_FREE;
                        end
                    end
                    FN_TAG:
                    begin
                        if (cmd_ok)
                        begin
                            tag_we = 1'b1;
                            ac_we  = 1'b1;
                        end
                    end
                    FN_ARM, FN_CANCEL:
                    begin
                        if (cmd_ok && status_reg[cmd_idx] == ST_ARMED)
                        begin
                            ctl.op    = OP_REMOVE;
                            st_we     = 1'b1;
                            canc_next = fn == FN_CANCEL;
                        end
                    end
                    FN_CANCEL_ALL:
                    begin
                        sweep_next = '0;
                    end
                    default:
                    begin
                        ctl.op = OP_HOLD;
                    end
                endcase
            end
            S_INSERT:
            begin
                ctl.op = OP_INSERT;
                st_we  = 1'b1;
                st_val = ST_ARMED;
            end
            S_SWEEP:
            begin
                op_slot = sweep_reg;
                st_idx  = sweep_reg;
                if (sweep_hit)
                begin
                    if (status_reg[sweep_reg] == ST_ARMED)
                        ctl.op = OP_REMOVE;
                    st_we  = 1'b1;
                    st_val = ST_FREE;
                end
                sweep_next = sweep_reg + 1'b1;
            end
            S_ACK:
            begin
                if (out_free)
                begin
                    emit                    = 1'b1;
                    emit_word.kind          = KIND_ACK;
                    emit_word.was_cancelled = canc_reg;
                    emit_word.last          = 1'b1;
                end
            end
            S_TICK:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (due)
                    begin
                        ctl.op             = OP_POP;
                        st_we              = 1'b1;
                        st_idx             = head_slot;
                        n_next             = n_reg + 1'b1;
                        emit_word.kind     = KIND_EXPIRY;
                        emit_word.out_slot = 5'(head_slot);
                        emit_word.last     = !more_due;
                        if (7'(tss_reg) == 7'(head_slot))
                        begin
                            emit_word.switch_request = 1'b1;
                        end
                        else
                        begin
                            emit_word.out_tag   = tag_reg[rd_idx];
                            emit_word.out_queue = queue_reg[rd_idx];
                        end
                    end
                    else
                    begin
                        emit_word.kind = KIND_ACK;
                        emit_word.last = 1'b1;
                    end
                end
            end
            default:
            begin
                ctl.op = OP_HOLD;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_word_next  = emit_word;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tick_reg      <= '0;
            tss_reg       <= TSS_W'(32);
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
            sweep_reg     <= '0;
            canc_reg      <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                status_reg[i] <= ST_FREE;
                ac_reg[i]     <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
            n_reg         <= n_next;
            sweep_reg     <= sweep_next;
            canc_reg      <= canc_next;
            if (cfg_we)
                tss_reg <= cfg_data;
            if (st_we)
                status_reg[st_idx] <= st_val;
            if (ac_we)
                ac_reg[ac_idx] <= ac_val;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        out_word_reg <= out_word_next;
        if (tag_we)
        begin
            tag_reg[cmd_idx]   <= cmd_reg.tag_value;
            queue_reg[cmd_idx] <= cmd_reg.queue_id;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule
